/* src/bmvp_pkg.sv */
// Package for the binary matrix-vector product block.
// Holds widths, mask reset values, register codes, the cell control struct
// and the mask bit selection function. No dependencies.
package bmvp_pkg;

    localparam int VECTOR_LENGTH = 4;
    localparam int ROW_COUNT     = 4;
    localparam int DATA_W        = 32;
    localparam int MASK_W        = 4;
    localparam int MASK_SEL_W    = $clog2(MASK_W);
    localparam int IDX_W         = $clog2(VECTOR_LENGTH);
    localparam int ROW_W         = $clog2(ROW_COUNT);
    localparam int CNT_W         = $clog2(ROW_COUNT + 1);
    localparam int CFG_INDEX_W   = 3;

    localparam logic [MASK_W-1:0] ROW_MASK_RESET [ROW_COUNT] = '{
        4'b1010, 4'b0011, 4'b1100, 4'b0101
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_ZERO  = 3'd0,
        REG_ROW_ONE   = 3'd1,
        REG_ROW_TWO   = 3'd2,
        REG_ROW_THREE = 3'd3
    } cfg_reg_t;

    // Per-cycle control broadcast to every row cell.
    typedef struct packed {
        logic             accept;     // element taken this cycle
        logic             first;      // element 0 of a vector: restart sum
        logic             load;       // last element: copy sum to output stage
        logic             shift;      // output stage moves one cell forward
        logic [IDX_W-1:0] elem_index;
    } cell_ctrl_t;

    // Mask bit for element k is bit VECTOR_LENGTH-1-k; positions past the
    // mask width select nothing.
    function automatic logic mask_select(input logic [MASK_W-1:0] mask,
                                         input logic [IDX_W-1:0]  k);
        logic [31:0] pos;
        pos = 32'(VECTOR_LENGTH - 1) - 32'(k);
        return (pos < 32'(MASK_W)) && mask[pos[MASK_SEL_W-1:0]];
    endfunction

endpackage

/* src/bmvp_cell.sv */
// One row cell: row mask, running accumulator and one output stage register.
// The output stages of all cells form a shift chain toward the output port.
// Depends on bmvp_pkg.
module bmvp_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bmvp_pkg::cell_ctrl_t          ctrl,
    input  logic [bmvp_pkg::MASK_W-1:0]   mask_init,
    input  logic                          cfg_we,
    input  logic [bmvp_pkg::MASK_W-1:0]   cfg_wdata,
    input  logic [bmvp_pkg::DATA_W-1:0]   element_value,
    input  logic [bmvp_pkg::DATA_W-1:0]   shift_in,
    output logic [bmvp_pkg::DATA_W-1:0]   sum_out
);

    logic [bmvp_pkg::MASK_W-1:0] mask_reg;
    logic [bmvp_pkg::DATA_W-1:0] acc_reg;
    logic [bmvp_pkg::DATA_W-1:0] stage_reg;
    logic [bmvp_pkg::DATA_W-1:0] part;
    logic [bmvp_pkg::DATA_W-1:0] acc_next;

    always_comb begin
        part     = bmvp_pkg::mask_select(mask_reg, ctrl.elem_index) ? element_value : '0;
        acc_next = ctrl.first ? part : acc_reg + part;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= mask_init;
        end else if (cfg_we) begin
            mask_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            acc_reg <= acc_next;
        end
        if (ctrl.load) begin
            stage_reg <= acc_next;
        end else if (ctrl.shift) begin
            stage_reg <= shift_in;
        end
    end

    assign sum_out = stage_reg;

endmodule

/* src/binary_matrix_vector_product_top.sv */
// Top level of the binary matrix-vector product block.
// Instantiates a chain of bmvp_cell row cells; depends on bmvp_pkg.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  s_      | in        | s_valid/s_ready  | s_element_value
//  m_      | out       | m_valid/m_ready  | m_row_index, m_row_sum, m_last_row
//  cfg_    | in        | cfg_we           | cfg_index, cfg_wdata (row masks)
//
// One element transaction per cycle: each row cell adds its masked share of
// the element into its accumulator in the same cycle it is accepted.
// The last element of a vector copies all row sums into the output stage
// chain; results then leave one per cycle while m_ready is high, row 0 first.
// The last element stalls only while the previous vector's results still
// occupy the chain (beyond the row being taken in that cycle).
// Reset (aresetn, synchronous, low) restores the masks and empties the chain.
module binary_matrix_vector_product_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // element input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bmvp_pkg::DATA_W-1:0]         s_element_value,
    // row results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bmvp_pkg::ROW_W-1:0]          m_row_index,
    output logic [bmvp_pkg::DATA_W-1:0]         m_row_sum,
    output logic                                m_last_row,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [bmvp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bmvp_pkg::MASK_W-1:0]         cfg_wdata
);

    logic [bmvp_pkg::IDX_W-1:0]   elem_idx_reg, elem_idx_next;
    logic [bmvp_pkg::CNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic                         last_elem;
    logic                         s_xfer;
    logic                         m_xfer;
    logic [bmvp_pkg::ROW_COUNT-1:0] row_we;
    bmvp_pkg::cell_ctrl_t         ctrl;
    logic [bmvp_pkg::DATA_W-1:0]  sums [bmvp_pkg::ROW_COUNT];

    assign last_elem = (elem_idx_reg == bmvp_pkg::IDX_W'(bmvp_pkg::VECTOR_LENGTH - 1));

    // Hold the last element back until the chain is free, or frees this cycle.
    assign s_ready = !last_elem || (out_cnt_reg == '0) ||
                     ((out_cnt_reg == bmvp_pkg::CNT_W'(1)) && m_ready);
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = (out_cnt_reg != '0);
    assign m_xfer  = m_valid && m_ready;

    always_comb begin
        ctrl.accept     = s_xfer;
        ctrl.first      = (elem_idx_reg == '0);
        ctrl.load       = s_xfer && last_elem;
        ctrl.shift      = m_xfer;
        ctrl.elem_index = elem_idx_reg;
    end

    always_comb begin
        elem_idx_next = elem_idx_reg;
        if (s_xfer) begin
            elem_idx_next = last_elem ? '0 : elem_idx_reg + bmvp_pkg::IDX_W'(1);
        end
        out_cnt_next = out_cnt_reg;
        if (ctrl.load) begin
            out_cnt_next = bmvp_pkg::CNT_W'(bmvp_pkg::ROW_COUNT);
        end else if (m_xfer) begin
            out_cnt_next = out_cnt_reg - bmvp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_idx_reg <= '0;
            out_cnt_reg  <= '0;
        end else begin
            elem_idx_reg <= elem_idx_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    // Register decode; indexes past the last row are dropped.
    always_comb begin
        row_we = '0;
        unique case (cfg_index)
            bmvp_pkg::REG_ROW_ZERO:  row_we[0] = cfg_we;
            bmvp_pkg::REG_ROW_ONE:   row_we[1] = cfg_we;
            bmvp_pkg::REG_ROW_TWO:   row_we[2] = cfg_we;
            bmvp_pkg::REG_ROW_THREE: row_we[3] = cfg_we;
            default:                 row_we    = '0;
        endcase
    end

    // Row cells; output stages shift toward cell 0, which feeds the port.
    for (genvar r = 0; r < bmvp_pkg::ROW_COUNT; r++) begin : g_cell
        logic [bmvp_pkg::DATA_W-1:0] chain_in;
        if (r == bmvp_pkg::ROW_COUNT - 1) begin : g_tail
            assign chain_in = '0;
        end else begin : g_link
            assign chain_in = sums[r+1];
        end
        bmvp_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .mask_init     (bmvp_pkg::ROW_MASK_RESET[r]),
            .cfg_we        (row_we[r]),
            .cfg_wdata     (cfg_wdata),
            .element_value (s_element_value),
            .shift_in      (chain_in),
            .sum_out       (sums[r])
        );
    end

    assign m_row_sum   = sums[0];
    assign m_row_index = bmvp_pkg::ROW_W'(bmvp_pkg::CNT_W'(bmvp_pkg::ROW_COUNT) - out_cnt_reg);
    assign m_last_row  = (out_cnt_reg == bmvp_pkg::CNT_W'(1));

    // Chain is loaded only when empty or when its final row drains this cycle.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |-> (out_cnt_reg == '0 ||
                       (out_cnt_reg == bmvp_pkg::CNT_W'(1) && m_ready)))
        else $error("chain loaded while results pending");

    a_load_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> (out_cnt_reg == bmvp_pkg::CNT_W'(bmvp_pkg::ROW_COUNT)))
        else $error("chain not full after load");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= bmvp_pkg::CNT_W'(bmvp_pkg::ROW_COUNT))
        else $error("result count out of range");

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_row) |->
            (m_row_index == bmvp_pkg::ROW_W'(bmvp_pkg::ROW_COUNT - 1)))
        else $error("last flag on wrong row");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        elem_idx_reg <= bmvp_pkg::IDX_W'(bmvp_pkg::VECTOR_LENGTH - 1))
        else $error("element index out of range");

endmodule
